// File: src/telnet_command_parser_macros.svh
// ----------------------------------------------------------------------------
// telnet command parser assertion macros
// shared concurrent assertion forms for the parser rtl
// ----------------------------------------------------------------------------
`ifndef TELNET_COMMAND_PARSER_MACROS_SVH
`define TELNET_COMMAND_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TNP_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TNP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tnp_pkg.sv
// ----------------------------------------------------------------------------
// tnp_pkg
// types and codes for the telnet command parser
// ----------------------------------------------------------------------------
package tnp_pkg;

   // subnegotiation buffer depth, only the naws header entries are kept
   localparam int SUB_DEPTH  = 16;
   localparam int SUB_IDX_W  = $clog2(SUB_DEPTH + 1);
   localparam int NAWS_LEN   = 5;

   // input kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_EOS  = 2'd1;
   localparam logic [1:0] KIND_WIN  = 2'd2;

   // telnet command bytes
   localparam logic [7:0] CMD_IAC  = 8'd255;
   localparam logic [7:0] CMD_DONT = 8'd254;
   localparam logic [7:0] CMD_DO   = 8'd253;
   localparam logic [7:0] CMD_WONT = 8'd252;
   localparam logic [7:0] CMD_WILL = 8'd251;
   localparam logic [7:0] CMD_SB   = 8'd250;
   localparam logic [7:0] CMD_EL   = 8'd248;
   localparam logic [7:0] CMD_EC   = 8'd247;
   localparam logic [7:0] CMD_AYT  = 8'd246;
   localparam logic [7:0] CMD_IP   = 8'd244;
   localparam logic [7:0] CMD_BRK  = 8'd243;
   localparam logic [7:0] CMD_DM   = 8'd242;
   localparam logic [7:0] CMD_SE   = 8'd240;
   localparam logic [7:0] CMD_EOR  = 8'd239;

   // option codes
   localparam logic [7:0] OPT_ECHO     = 8'd1;
   localparam logic [7:0] OPT_SGA      = 8'd3;
   localparam logic [7:0] OPT_NAWS     = 8'd31;
   localparam logic [7:0] OPT_LINEMODE = 8'd34;

   // characters
   localparam logic [7:0] CHR_NUL  = 8'h00;
   localparam logic [7:0] CHR_ETX  = 8'h03;
   localparam logic [7:0] CHR_BS   = 8'h08;
   localparam logic [7:0] CHR_LF   = 8'h0a;
   localparam logic [7:0] CHR_CR   = 8'h0d;
   localparam logic [7:0] EOF_RESET = 8'h04;

   // events
   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_DM   = 3'd1;
   localparam logic [2:0] EV_SB   = 3'd2;
   localparam logic [2:0] EV_SE   = 3'd3;
   localparam logic [2:0] EV_EOR  = 3'd4;

   // messages
   localparam logic [1:0] MSG_NONE = 2'd0;
   localparam logic [1:0] MSG_AYT  = 2'd1;
   localparam logic [1:0] MSG_IP   = 2'd2;
   localparam logic [1:0] MSG_BRK  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] new_rows;
      logic [15:0] new_cols;
   } req_type;

   typedef struct packed {
      logic        char_valid;
      logic [7:0]  char_value;
      logic [2:0]  event_res;
      logic [1:0]  reply_count;
      logic [7:0]  reply1_cmd;
      logic [7:0]  reply1_opt;
      logic [7:0]  reply2_cmd;
      logic [7:0]  reply2_opt;
      logic [1:0]  message;
      logic [15:0] win_width;
      logic [15:0] win_height;
   } rsp_type;

endpackage

// File: src/telnet_command_parser.sv
// ----------------------------------------------------------------------------
// telnet_command_parser
// telnet receive parser: strips iac sequences, answers option requests,
// collects subnegotiation and tracks the naws window size
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one word per item: a received byte, an end-of-stream
//   report or a window-size setting. rsp_* returns exactly one word per
//   item in order: delivered character, event, up to two option replies,
//   message code and the current window size.
//   csr_wr_en/csr_wr_data load the end-of-stream character (reset 0x04).
// timing:
//   an accepted word lands in an input register; once the result register
//   is free or being emptied, the parser logic runs and the result register
//   loads, raising rsp_valid. one word per cycle is sustained while rsp_ready
//   stays high, set by the single parser stage between the registers.
// reset:
//   synchronous, clears parser mode, cr flag, subnegotiation index and
//   buffer header, window size and both pipeline valids.
// stall:
//   while rsp_ready is low the result holds, the input register holds one
//   more word, and req_ready drops once both are full.
// ----------------------------------------------------------------------------
`include "telnet_command_parser_macros.svh"

module telnet_command_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  tnp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tnp_pkg::rsp_type rsp_data
);
   import tnp_pkg::*;

   localparam logic [2:0] M_NORMAL = 3'd0;
   localparam logic [2:0] M_IAC    = 3'd1;
   localparam logic [2:0] M_SB_IAC = 3'd2;
   localparam logic [2:0] M_SB     = 3'd3;
   localparam logic [2:0] M_WILL   = 3'd4;
   localparam logic [2:0] M_DO     = 3'd5;
   localparam logic [2:0] M_DONT   = 3'd6;
   localparam logic [2:0] M_WONT   = 3'd7;

   logic                 in_valid_ff, in_valid_in;
   req_type              in_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [7:0]           eof_char_ff;
   logic [2:0]           mode_ff, mode_in;
   logic [SUB_IDX_W-1:0] sub_idx_ff, sub_idx_in;
   logic [7:0]           naws_buf_ff [NAWS_LEN];
   logic [7:0]           naws_buf_in [NAWS_LEN];
   logic                 last_cr_ff, last_cr_in;
   logic [15:0]          width_ff, width_in;
   logic [15:0]          height_ff, height_in;
   logic                 advance;
   logic                 req_fire;
   logic [7:0]           v;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign v         = in_data_ff.data_byte;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // parser stage
   always_comb begin
      rsp_data_in = '0;
      mode_in     = mode_ff;
      sub_idx_in  = sub_idx_ff;
      naws_buf_in = naws_buf_ff;
      last_cr_in  = last_cr_ff;
      width_in    = width_ff;
      height_in   = height_ff;

      case (in_data_ff.kind)
         KIND_BYTE: begin
            mode_in = M_NORMAL;
            case (mode_ff)
               M_IAC, M_SB_IAC: begin
                  case (v)
                     CMD_IAC: begin
                        rsp_data_in.char_valid = 1'b1;
                        rsp_data_in.char_value = CMD_IAC;
                        mode_in = (mode_ff == M_SB_IAC) ? M_SB : M_NORMAL;
                     end
                     CMD_DONT: mode_in = M_DONT;
                     CMD_DO:   mode_in = M_DO;
                     CMD_WONT: mode_in = M_WONT;
                     CMD_WILL: mode_in = M_WILL;
                     CMD_SB: begin
                        mode_in               = M_SB;
                        sub_idx_in            = '0;
                        rsp_data_in.event_res = EV_SB;
                     end
                     CMD_EL: begin
                        rsp_data_in.char_valid = 1'b1;
                        rsp_data_in.char_value = CHR_ETX;
                     end
                     CMD_EC: begin
                        rsp_data_in.char_valid = 1'b1;
                        rsp_data_in.char_value = CHR_BS;
                     end
                     CMD_AYT: rsp_data_in.message   = MSG_AYT;
                     CMD_IP:  rsp_data_in.message   = MSG_IP;
                     CMD_BRK: rsp_data_in.message   = MSG_BRK;
                     CMD_DM:  rsp_data_in.event_res = EV_DM;
                     CMD_SE: begin
                        // header entries may be stale from an earlier block
                        if (naws_buf_ff[0] == OPT_NAWS) begin
                           width_in  = {naws_buf_ff[1], naws_buf_ff[2]};
                           height_in = {naws_buf_ff[3], naws_buf_ff[4]};
                        end
                        rsp_data_in.event_res = EV_SE;
                     end
                     CMD_EOR: rsp_data_in.event_res = EV_EOR;
                     default: ;
                  endcase
               end
               M_SB: begin
                  if (v == CMD_IAC) begin
                     mode_in = M_SB_IAC;
                  end else begin
                     mode_in = M_SB;
                     if (sub_idx_ff < SUB_IDX_W'(SUB_DEPTH)) begin
                        // only the naws header bytes are ever read back
                        for (int i = 0; i < NAWS_LEN; i++) begin
                           if (sub_idx_ff == SUB_IDX_W'(i)) begin
                              naws_buf_in[i] = v;
                           end
                        end
                        sub_idx_in = sub_idx_ff + 1'b1;
                     end
                  end
               end
               M_WILL: begin
                  if (v == OPT_LINEMODE) begin
                     rsp_data_in.reply_count = 2'd2;
                     rsp_data_in.reply1_cmd  = CMD_DONT;
                     rsp_data_in.reply1_opt  = OPT_LINEMODE;
                     rsp_data_in.reply2_cmd  = CMD_DO;
                     rsp_data_in.reply2_opt  = OPT_ECHO;
                  end else begin
                     rsp_data_in.reply_count = 2'd1;
                     rsp_data_in.reply1_cmd  = (v == OPT_NAWS) ? CMD_DO : CMD_DONT;
                     rsp_data_in.reply1_opt  = v;
                  end
               end
               M_DO: begin
                  rsp_data_in.reply_count = 2'd1;
                  rsp_data_in.reply1_cmd  = (v inside {OPT_SGA, OPT_ECHO}) ?
                                            CMD_WILL : CMD_WONT;
                  rsp_data_in.reply1_opt  = v;
               end
               M_WONT: begin
                  rsp_data_in.reply_count = 2'd1;
                  rsp_data_in.reply1_cmd  = (v == OPT_ECHO) ? CMD_WILL : CMD_WONT;
                  rsp_data_in.reply1_opt  = v;
               end
               M_DONT: ;
               default: begin
                  if (v == CMD_IAC) begin
                     mode_in = M_IAC;
                  end else begin
                     // drop lf or nul right after cr
                     if (!((v inside {CHR_LF, CHR_NUL}) && last_cr_ff)) begin
                        rsp_data_in.char_valid = 1'b1;
                        rsp_data_in.char_value = v;
                     end
                     last_cr_in = (v == CHR_CR);
                  end
               end
            endcase
         end
         KIND_EOS: begin
            rsp_data_in.char_valid = 1'b1;
            rsp_data_in.char_value = eof_char_ff;
         end
         KIND_WIN: begin
            height_in = in_data_ff.new_rows;
            width_in  = in_data_ff.new_cols;
         end
         default: ;
      endcase

      rsp_data_in.win_width  = width_in;
      rsp_data_in.win_height = height_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eof_char_ff  <= EOF_RESET;
         mode_ff      <= M_NORMAL;
         sub_idx_ff   <= '0;
         last_cr_ff   <= 1'b0;
         width_ff     <= '0;
         height_ff    <= '0;
         for (int i = 0; i < NAWS_LEN; i++) begin
            naws_buf_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            eof_char_ff <= csr_wr_data;
         end
         if (advance) begin
            mode_ff     <= mode_in;
            sub_idx_ff  <= sub_idx_in;
            naws_buf_ff <= naws_buf_in;
            last_cr_ff  <= last_cr_in;
            width_ff    <= width_in;
            height_ff   <= height_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `TNP_ASSERT_NEXT(a_advance_gives_rsp, clock, reset, advance, rsp_valid_ff,
      "parser stage advanced but no result word followed")
   `TNP_ASSERT_IMPL(a_sub_idx_bound, clock, reset, 1'b1,
      sub_idx_ff <= SUB_IDX_W'(SUB_DEPTH), "subnegotiation index past buffer depth")
   `TNP_ASSERT_IMPL(a_no_char_zero, clock, reset,
      rsp_valid_ff && !rsp_data_ff.char_valid, rsp_data_ff.char_value == '0,
      "character value set without char_valid")
   `TNP_ASSERT_IMPL(a_reply_cmds, clock, reset,
      rsp_valid_ff && rsp_data_ff.reply_count != 2'd0,
      rsp_data_ff.reply1_cmd == CMD_WILL || rsp_data_ff.reply1_cmd == CMD_WONT ||
      rsp_data_ff.reply1_cmd == CMD_DO || rsp_data_ff.reply1_cmd == CMD_DONT,
      "reply carries a non-negotiation command")

endmodule

// File: sim/telnet_command_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telnet_command_parser_test
// self-checking bench for the telnet receive parser: a queue-fed driver
// offers byte, end-of-stream and window-size words with random gaps, a
// stalling receiver takes the results, and every result word is compared
// against a behavioral parser kept in the bench. the end-of-stream
// character is changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module telnet_command_parser_test;
   import tnp_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int PHASE_WORDS = 230;

   typedef enum logic [2:0] {
      PS_NORMAL, PS_IAC, PS_SB_IAC, PS_SB, PS_WILL, PS_DO, PS_DONT, PS_WONT
   } parse_state_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   telnet_command_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // parser copy kept by the bench
   parse_state_type parse_state;
   int              sub_fill;
   logic [7:0]      sub_bytes [SUB_DEPTH];
   logic            after_cr;
   logic [15:0]     win_cols;
   logic [15:0]     win_rows;
   logic [7:0]      eof_setting;

   req_type pending_words [$];
   rsp_type expected_results [$];
   int      words_queued = 0;
   int      issued_count = 0;
   int      taken_count = 0;
   int      error_count = 0;
   logic    req_taken = 1'b0;
   int      send_gap = 0;
   int      send_steady = 0;
   int      hold_left = 0;
   int      recv_steady = 0;
   bit      long_hold_done = 1'b0;

   function automatic rsp_type with_reply(rsp_type o, logic [7:0] cmd, logic [7:0] opt);
      if (o.reply_count == 2'd0) begin
         o.reply1_cmd = cmd;
         o.reply1_opt = opt;
      end else begin
         o.reply2_cmd = cmd;
         o.reply2_opt = opt;
      end
      o.reply_count = o.reply_count + 2'd1;
      return o;
   endfunction

   function automatic rsp_type with_char(rsp_type o, logic [7:0] c);
      o.char_valid = 1'b1;
      o.char_value = c;
      return o;
   endfunction

   function automatic rsp_type run_command(rsp_type o, logic [7:0] cmd, bit in_sb);
      parse_state = PS_NORMAL;
      case (cmd)
         CMD_IAC: begin
            o = with_char(o, CMD_IAC);
            parse_state = in_sb ? PS_SB : PS_NORMAL;
         end
         CMD_DONT: parse_state = PS_DONT;
         CMD_DO:   parse_state = PS_DO;
         CMD_WONT: parse_state = PS_WONT;
         CMD_WILL: parse_state = PS_WILL;
         CMD_SB: begin
            parse_state = PS_SB;
            sub_fill = 0;
            o.event_res = EV_SB;
         end
         CMD_EL:  o = with_char(o, CHR_ETX);
         CMD_EC:  o = with_char(o, CHR_BS);
         CMD_AYT: o.message = MSG_AYT;
         CMD_IP:  o.message = MSG_IP;
         CMD_BRK: o.message = MSG_BRK;
         CMD_DM:  o.event_res = EV_DM;
         CMD_SE: begin
            // header bytes may be stale from an earlier block
            if (sub_bytes[0] == OPT_NAWS) begin
               win_cols = {sub_bytes[1], sub_bytes[2]};
               win_rows = {sub_bytes[3], sub_bytes[4]};
            end
            o.event_res = EV_SE;
         end
         CMD_EOR: o.event_res = EV_EOR;
         default: ;
      endcase
      return o;
   endfunction

   function automatic rsp_type parse_byte(rsp_type o, logic [7:0] b);
      parse_state_type prev;
      prev = parse_state;
      parse_state = PS_NORMAL;
      case (prev)
         PS_IAC:    o = run_command(o, b, 1'b0);
         PS_SB_IAC: o = run_command(o, b, 1'b1);
         PS_SB: begin
            if (b == CMD_IAC) begin
               parse_state = PS_SB_IAC;
            end else begin
               parse_state = PS_SB;
               if (sub_fill < SUB_DEPTH) begin
                  sub_bytes[sub_fill] = b;
                  sub_fill++;
               end
            end
         end
         PS_WILL: begin
            if (b == OPT_LINEMODE) begin
               o = with_reply(o, CMD_DONT, OPT_LINEMODE);
               o = with_reply(o, CMD_DO, OPT_ECHO);
            end else if (b == OPT_NAWS) begin
               o = with_reply(o, CMD_DO, OPT_NAWS);
            end else begin
               o = with_reply(o, CMD_DONT, b);
            end
         end
         PS_DO: begin
            if (b == OPT_SGA || b == OPT_ECHO) o = with_reply(o, CMD_WILL, b);
            else o = with_reply(o, CMD_WONT, b);
         end
         PS_WONT: begin
            if (b == OPT_ECHO) o = with_reply(o, CMD_WILL, OPT_ECHO);
            else o = with_reply(o, CMD_WONT, b);
         end
         PS_DONT: ;
         default: begin
            if (b == CMD_IAC) begin
               parse_state = PS_IAC;
            end else begin
               // lf or nul right after cr is swallowed
               if (!((b == CHR_LF || b == CHR_NUL) && after_cr)) o = with_char(o, b);
               after_cr = (b == CHR_CR);
            end
         end
      endcase
      return o;
   endfunction

   function automatic rsp_type predict_result(req_type w);
      rsp_type o;
      o = '0;
      case (w.kind)
         KIND_BYTE: o = parse_byte(o, w.data_byte);
         KIND_EOS:  o = with_char(o, eof_setting);
         KIND_WIN: begin
            win_rows = w.new_rows;
            win_cols = w.new_cols;
         end
         default: ;
      endcase
      o.win_width = win_cols;
      o.win_height = win_rows;
      return o;
   endfunction

   task automatic compare_result(rsp_type exp, rsp_type act);
      if (act.char_valid !== exp.char_valid) begin
         $error("char_valid: expected %0d, actual %0d", exp.char_valid, act.char_valid);
         error_count++;
      end
      if (act.char_value !== exp.char_value) begin
         $error("char_value: expected %0d, actual %0d", exp.char_value, act.char_value);
         error_count++;
      end
      if (act.event_res !== exp.event_res) begin
         $error("event_res: expected %0d, actual %0d", exp.event_res, act.event_res);
         error_count++;
      end
      if (act.reply_count !== exp.reply_count) begin
         $error("reply_count: expected %0d, actual %0d", exp.reply_count, act.reply_count);
         error_count++;
      end
      if (act.reply1_cmd !== exp.reply1_cmd) begin
         $error("reply1_cmd: expected %0d, actual %0d", exp.reply1_cmd, act.reply1_cmd);
         error_count++;
      end
      if (act.reply1_opt !== exp.reply1_opt) begin
         $error("reply1_opt: expected %0d, actual %0d", exp.reply1_opt, act.reply1_opt);
         error_count++;
      end
      if (act.reply2_cmd !== exp.reply2_cmd) begin
         $error("reply2_cmd: expected %0d, actual %0d", exp.reply2_cmd, act.reply2_cmd);
         error_count++;
      end
      if (act.reply2_opt !== exp.reply2_opt) begin
         $error("reply2_opt: expected %0d, actual %0d", exp.reply2_opt, act.reply2_opt);
         error_count++;
      end
      if (act.message !== exp.message) begin
         $error("message: expected %0d, actual %0d", exp.message, act.message);
         error_count++;
      end
      if (act.win_width !== exp.win_width) begin
         $error("win_width: expected %0d, actual %0d", exp.win_width, act.win_width);
         error_count++;
      end
      if (act.win_height !== exp.win_height) begin
         $error("win_height: expected %0d, actual %0d", exp.win_height, act.win_height);
         error_count++;
      end
   endtask

   // result check, then prediction for the word taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         parse_state = PS_NORMAL;
         sub_fill = 0;
         for (int i = 0; i < SUB_DEPTH; i++) sub_bytes[i] = '0;
         after_cr = 1'b0;
         win_cols = '0;
         win_rows = '0;
         eof_setting = EOF_RESET;
         expected_results.delete();
         req_taken <= 1'b0;
      end else begin
         if (csr_wr_en) eof_setting = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               compare_result(expected_results.pop_front(), rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_result(req_data));
            taken_count++;
         end
         req_taken <= req_valid && req_ready;
      end
   end

   function automatic int pick_send_gap();
      int r;
      if (send_steady > 0) begin
         send_steady--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         send_steady = $urandom_range(40, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // word still waiting, hold it
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (pending_words.size() != 0) begin
         req_data <= pending_words.pop_front();
         req_valid <= 1'b1;
         issued_count++;
         send_gap = pick_send_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!long_hold_done && issued_count >= 300) begin
         // long back-pressure so the block fills and drops req_ready
         rsp_ready <= 1'b0;
         hold_left = 64;
         long_hold_done = 1'b1;
      end else if (recv_steady > 0) begin
         rsp_ready <= 1'b1;
         recv_steady--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            rsp_ready <= 1'b1;
            recv_steady = $urandom_range(40, 120);
         end else if (r < 4) begin
            rsp_ready <= 1'b0;
            hold_left = $urandom_range(20, 60);
         end else if (r < 25) begin
            rsp_ready <= 1'b0;
            hold_left = $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_word(logic [1:0] kind, logic [7:0] b);
      req_type w;
      w.kind = kind;
      w.data_byte = b;
      w.new_rows = 16'($urandom);
      w.new_cols = 16'($urandom);
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic queue_byte(logic [7:0] b);
      queue_word(KIND_BYTE, b);
   endtask

   // 255 inside a subnegotiation travels doubled
   task automatic queue_sub_byte(logic [7:0] b);
      if (b == CMD_IAC) queue_byte(CMD_IAC);
      queue_byte(b);
   endtask

   task automatic queue_window(logic [15:0] rows, logic [15:0] cols);
      req_type w;
      w.kind = KIND_WIN;
      w.data_byte = 8'($urandom);
      w.new_rows = rows;
      w.new_cols = cols;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic queue_random_sequence();
      int r;
      int n;
      logic [7:0] b;
      logic [7:0] opts [4];
      logic [7:0] negs [4];
      logic [7:0] cmds [10];
      opts = '{OPT_ECHO, OPT_SGA, OPT_NAWS, OPT_LINEMODE};
      negs = '{CMD_WILL, CMD_DO, CMD_WONT, CMD_DONT};
      cmds = '{CMD_IAC, CMD_EL, CMD_EC, CMD_AYT, CMD_IP, CMD_BRK, CMD_DM, CMD_SE,
               CMD_EOR, CMD_SB};
      r = $urandom_range(0, 99);
      if (r < 35) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            case ($urandom_range(0, 7))
               0: b = CHR_CR;
               1: b = CHR_LF;
               2: b = CHR_NUL;
               default: b = 8'($urandom_range(0, 254));
            endcase
            queue_byte(b);
         end
      end else if (r < 50) begin
         queue_byte(CMD_IAC);
         queue_byte(negs[$urandom_range(0, 3)]);
         if ($urandom_range(0, 1)) queue_byte(opts[$urandom_range(0, 3)]);
         else queue_byte(8'($urandom));
      end else if (r < 63) begin
         queue_byte(CMD_IAC);
         if ($urandom_range(0, 3) != 0) queue_byte(cmds[$urandom_range(0, 9)]);
         else queue_byte(8'($urandom));
      end else if (r < 85) begin
         queue_byte(CMD_IAC);
         queue_byte(CMD_SB);
         if ($urandom_range(0, 9) < 6) begin
            queue_sub_byte(OPT_NAWS);
            repeat (4) queue_sub_byte(8'($urandom));
         end else begin
            n = $urandom_range(0, 20);
            repeat (n) queue_sub_byte(8'($urandom));
         end
         r = $urandom_range(0, 9);
         if (r < 8) begin
            queue_byte(CMD_IAC);
            queue_byte(CMD_SE);
         end else if (r < 9) begin
            queue_byte(CMD_IAC);
            queue_byte(cmds[$urandom_range(0, 9)]);
         end
      end else if (r < 90) begin
         queue_word(KIND_EOS, 8'($urandom));
      end else if (r < 96) begin
         queue_window(16'($urandom), 16'($urandom));
      end else if (r < 98) begin
         queue_word(KIND_UNUSED, 8'($urandom));
      end else begin
         queue_byte(8'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (!(pending_words.size() == 0 && issued_count == taken_count
               && expected_results.size() == 0))
         @(negedge clock);
   endtask

   task automatic write_eof_char(logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int start;
      logic [7:0] eof_value;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: edge bytes, cr handling, escapes, replies, naws
      queue_byte(8'hfe);
      queue_byte(CHR_CR);
      queue_byte(CHR_LF);
      queue_byte(CHR_CR);
      queue_byte(CHR_NUL);
      queue_byte(CHR_NUL);
      queue_byte(CMD_IAC);
      queue_byte(CMD_IAC);
      queue_byte(CMD_IAC);
      queue_byte(CMD_WILL);
      queue_byte(OPT_LINEMODE);
      queue_byte(CMD_IAC);
      queue_byte(CMD_DO);
      queue_byte(OPT_SGA);
      queue_word(KIND_EOS, 8'hff);
      queue_window(16'hffff, 16'h0000);
      queue_word(KIND_UNUSED, 8'h00);
      queue_byte(CMD_IAC);
      queue_byte(CMD_SB);
      queue_byte(OPT_NAWS);
      queue_byte(8'h00);
      queue_byte(8'h50);
      queue_byte(8'h00);
      queue_byte(8'h18);
      queue_byte(CMD_IAC);
      queue_byte(CMD_SE);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         eof_value = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hff : 8'($urandom);
         write_eof_char(eof_value);
         start = words_queued;
         while (words_queued - start < PHASE_WORDS) queue_random_sequence();
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: telnet_command_parser.f
+incdir+src
src/tnp_pkg.sv
src/telnet_command_parser.sv
sim/telnet_command_parser_test.sv
